[src/bfcw_pkg.sv]
package bfcw_pkg;

  localparam int MAX_ATOMS = 32;
  localparam int IDX_W     = $clog2(MAX_ATOMS);
  localparam int CNT_W     = IDX_W + 1;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [30:0] ONE_Q30        = 31'h4000_0000;
  localparam logic [30:0] HALF_Q30       = 31'h2000_0000;
  localparam logic [30:0] THREE_HALF_Q30 = 31'h6000_0000;

  typedef struct packed {
    logic              action;
    logic [4:0]        atom_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic [23:0]       atom_radius;
  } bfcw_in_t;

  typedef struct packed {
    logic [30:0] weight;
    logic        error;
  } bfcw_out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [23:0]        size;
  } bfcw_atom_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_READ, OP_DIFF_G, OP_DIFF_B, OP_MUL_X, OP_MUL_Y, OP_MUL_Z, OP_ACC,
    OP_SQRT_DIST, OP_SQRT_SIZE, OP_WR_PRE, OP_LATCH_B, OP_LATCH_DBC, OP_DIV_U,
    OP_LATCH_U, OP_MUL_UU, OP_DIV_A, OP_LATCH_A, OP_DIV_MU, OP_LATCH_MU, OP_MUL_MM,
    OP_MUL_NA, OP_NU, OP_MUL_NN, OP_MUL_NM, OP_NU_RND, OP_MUL_CS, OP_CELL,
    OP_ACC_CELL, OP_DIV_W, OP_RES_OK, OP_RES_ERR
  } dp_op_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_P_RD, ST_P_DIFF, ST_MX, ST_MY, ST_MZ, ST_ACC, ST_SQ, ST_SQ_WAIT,
    ST_P_SIZE, ST_P_WAIT, ST_P_WR, ST_B_RD, ST_B_LATCH, ST_C_CHK, ST_C_RD, ST_C_DIFF,
    ST_C_DBC, ST_C_CHKZ, ST_U_DIV, ST_U_WAIT, ST_U_LATCH, ST_U2, ST_A_DIV, ST_A_WAIT,
    ST_A_LATCH, ST_MU_DIV, ST_MU_WAIT, ST_MU_LATCH, ST_MM, ST_NA, ST_NU, ST_R1, ST_R2,
    ST_R3, ST_S, ST_CELL, ST_B_END, ST_F_CHK, ST_F_DIV, ST_F_WAIT, ST_OK, ST_ERR
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] addr;
    logic             take;
    logic             target;
  } bfcw_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
    logic dbc_zero;
    logic sum_zero;
  } bfcw_status_t;

endpackage

[src/bfcw_sqrt.sv]
module bfcw_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] operand,
  output logic        done,
  output logic [31:0] root
);
  logic        run;
  logic [4:0]  cnt;
  logic [63:0] v;
  logic [33:0] rem;
  logic [35:0] r2;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;

  always_comb begin
    r2    = {rem, v[63:62]};
    trial = {2'b00, root, 2'b01};
    diff  = r2 - trial;
    ge    = (r2 >= trial);
  end

  // two operand bits per cycle, one root bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == 5'd31) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= operand;
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (run) begin
      rem  <= ge ? diff[33:0] : r2[33:0];
      root <= {root[30:0], ge};
      v    <= {v[61:0], 2'b00};
      cnt  <= cnt + 5'd1;
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !run)
    else $error("sqrt started while running");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !run)
    else $error("sqrt done while still running");

endmodule

[src/bfcw_div.sv]
module bfcw_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [62:0] num,
  input  logic [35:0] den,
  input  logic [30:0] lim,
  output logic        done,
  output logic [30:0] q
);
  logic        run;
  logic [4:0]  cnt;
  logic [35:0] den_r;
  logic [30:0] lim_r;
  logic [35:0] rem;
  logic [30:0] lo;
  logic [30:0] quo;
  logic        sat;
  logic [36:0] r2;
  logic [36:0] diff;
  logic        ge;

  always_comb begin
    // quotient would need 32 bits or more: always above the limit
    sat  = ({4'b0000, num[62:31]} >= den);
    r2   = {rem, lo[30]};
    diff = r2 - {1'b0, den_r};
    ge   = (r2 >= {1'b0, den_r});
    q    = (quo > lim_r) ? lim_r : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= !sat;
        done <= sat;
      end else if (run && cnt == 5'd30) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      lim_r <= lim;
      rem   <= {4'b0000, num[62:31]};
      lo    <= num[30:0];
      cnt   <= '0;
      quo   <= lim;
    end else if (run) begin
      rem <= ge ? diff[35:0] : r2[35:0];
      quo <= {quo[29:0], ge};
      lo  <= {lo[29:0], 1'b0};
      cnt <= cnt + 5'd1;
    end
  end

  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !run)
    else $error("divider started while running");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !run)
    else $error("divider done while still running");

endmodule

[src/bfcw_datapath.sv]
module bfcw_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  bfcw_pkg::bfcw_cmd_t   cmd,
  input  bfcw_pkg::bfcw_in_t    item,
  output bfcw_pkg::bfcw_status_t status,
  output logic                  res_valid,
  output bfcw_pkg::bfcw_out_t   res
);
  import bfcw_pkg::*;

  bfcw_atom_t  atom_mem [MAX_ATOMS];
  logic [52:0] pre_mem  [MAX_ATOMS];   // {grid distance, size root}

  bfcw_atom_t  ar;
  logic [52:0] pr;
  logic signed [31:0] gx, gy, gz, bx, by, bz;
  logic [30:0] dx, dy, dz;
  logic [61:0] acc;
  logic [63:0] prod;
  logic [30:0] dgb, dgc, dgtmp, dbc;
  logic [21:0] sqb, sqc;
  logic        u_neg, a_neg, mu_neg, nu_neg;
  logic [30:0] u_mag, a_mag, mu_mag, nu_mag;
  logic [30:0] cell_prod, tcell;
  logic [35:0] sum;

  logic [31:0] mul_a, mul_b;
  logic        sqrt_start, div_start;
  logic [63:0] sqrt_op;
  logic [31:0] root;
  logic        sqrt_done;
  logic [62:0] div_num;
  logic [35:0] div_den;
  logic [30:0] div_lim;
  logic [30:0] div_q;
  logic        div_done;

  logic [21:0] sq_diff;
  logic [30:0] dg_diff;
  logic [30:0] u2c, den_a, t_na, m_r, s_val;
  logic [31:0] s_full;
  logic [23:0] rad;
  logic signed [33:0] mu_sv, na_sv, nu_sum;
  logic [33:0] nu_abs;
  logic [30:0] nu_cl;

  function automatic logic [30:0] absdiff(input logic signed [31:0] p,
                                          input logic signed [31:0] r);
    logic signed [32:0] d;
    logic [32:0] m;
    d = {p[31], p} - {r[31], r};
    m = d[32] ? 33'(-d) : 33'(d);
    return m[32:2];
  endfunction

  always_comb begin
    sq_diff = (sqb >= sqc) ? sqb - sqc : sqc - sqb;
    dg_diff = (dgb >= dgc) ? dgb - dgc : dgc - dgb;
    u2c     = (prod[63:30] >= {3'b000, ONE_Q30}) ? ONE_Q30 - 31'd1 : prod[60:30];
    den_a   = ONE_Q30 - u2c;
    t_na    = ONE_Q30 - prod[60:30];
    m_r     = THREE_HALF_Q30 - {1'b0, prod[60:31]};
    s_full  = nu_neg ? {1'b0, ONE_Q30} + {1'b0, nu_mag} : {1'b0, ONE_Q30} - {1'b0, nu_mag};
    s_val   = s_full[31:1];
    rad     = (ar.size == '0) ? 24'd1 : ar.size;

    mu_sv = $signed({3'b000, mu_mag});
    if (mu_neg) mu_sv = -mu_sv;
    na_sv = $signed({1'b0, prod[62:30]});
    if (a_neg) na_sv = -na_sv;
    nu_sum = mu_sv + na_sv;
    nu_abs = nu_sum[33] ? 34'(-nu_sum) : 34'(nu_sum);
    nu_cl  = (nu_abs > {3'b000, ONE_Q30}) ? ONE_Q30 : nu_abs[30:0];
  end

  // one shared multiplier, all operands are magnitudes
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_X:  begin mul_a = {1'b0, dx};        mul_b = {1'b0, dx};     end
      OP_MUL_Y:  begin mul_a = {1'b0, dy};        mul_b = {1'b0, dy};     end
      OP_MUL_Z:  begin mul_a = {1'b0, dz};        mul_b = {1'b0, dz};     end
      OP_MUL_UU: begin mul_a = {1'b0, u_mag};     mul_b = {1'b0, u_mag};  end
      OP_MUL_MM: begin mul_a = {1'b0, mu_mag};    mul_b = {1'b0, mu_mag}; end
      OP_MUL_NA: begin mul_a = {1'b0, a_mag};     mul_b = {1'b0, t_na};   end
      OP_MUL_NN: begin mul_a = {1'b0, nu_mag};    mul_b = {1'b0, nu_mag}; end
      OP_MUL_NM: begin mul_a = {1'b0, nu_mag};    mul_b = {1'b0, m_r};    end
      OP_MUL_CS: begin mul_a = {1'b0, cell_prod}; mul_b = {1'b0, s_val};  end
      default:   begin mul_a = '0;                mul_b = '0;             end
    endcase
  end

  always_comb begin
    sqrt_start = 1'b0;
    sqrt_op    = {2'b00, acc};
    div_start  = 1'b0;
    div_num    = {2'b00, dg_diff, 30'd0};
    div_den    = {5'd0, dbc};
    div_lim    = ONE_Q30;
    case (cmd.op)
      OP_SQRT_DIST: sqrt_start = 1'b1;
      OP_SQRT_SIZE: begin
        sqrt_start = 1'b1;
        sqrt_op    = {20'd0, rad, 20'd0};
      end
      OP_DIV_U: begin
        div_start = 1'b1;
        div_num   = {11'd0, sq_diff, 30'd0};
        div_den   = {13'd0, {1'b0, sqb} + {1'b0, sqc}};
      end
      OP_DIV_A: begin
        div_start = 1'b1;
        div_num   = {2'b00, u_mag, 30'd0};
        div_den   = {5'd0, den_a};
        div_lim   = HALF_Q30;
      end
      OP_DIV_MU: div_start = 1'b1;
      OP_DIV_W: begin
        div_start = 1'b1;
        div_num   = {2'b00, tcell, 30'd0};
        div_den   = sum;
      end
      default: begin
        sqrt_start = 1'b0;
        div_start  = 1'b0;
      end
    endcase
  end

  bfcw_sqrt u_sqrt (
    .clk, .rst, .start(sqrt_start), .operand(sqrt_op), .done(sqrt_done), .root
  );

  bfcw_div u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(div_den), .lim(div_lim),
    .done(div_done), .q(div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.take && item.action == ACT_LOAD) begin
      atom_mem[item.atom_index] <= '{x: item.coord_x, y: item.coord_y,
                                     z: item.coord_z, size: item.atom_radius};
    end
    if (cmd.op == OP_WR_PRE) begin
      pre_mem[cmd.addr] <= {dgtmp, root[21:0]};
    end
    if (cmd.op == OP_READ) begin
      ar <= atom_mem[cmd.addr];
      pr <= pre_mem[cmd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      gx  <= item.coord_x;
      gy  <= item.coord_y;
      gz  <= item.coord_z;
      sum <= '0;
    end
    // product is only read in the cycle right after its multiply op
    prod <= mul_a * mul_b;
    case (cmd.op)
      OP_DIFF_G: begin
        dx <= absdiff(ar.x, gx);
        dy <= absdiff(ar.y, gy);
        dz <= absdiff(ar.z, gz);
      end
      OP_DIFF_B: begin
        dx  <= absdiff(ar.x, bx);
        dy  <= absdiff(ar.y, by);
        dz  <= absdiff(ar.z, bz);
        dgc <= pr[52:22];
        sqc <= pr[21:0];
      end
      OP_MUL_Y:     acc <= prod[61:0];
      OP_MUL_Z:     acc <= acc + prod[61:0];
      OP_ACC:       acc <= acc + prod[61:0];
      OP_SQRT_SIZE: dgtmp <= root[30:0];
      OP_LATCH_B: begin
        bx        <= ar.x;
        by        <= ar.y;
        bz        <= ar.z;
        dgb       <= pr[52:22];
        sqb       <= pr[21:0];
        cell_prod <= ONE_Q30;
      end
      OP_LATCH_DBC: dbc <= root[30:0];
      OP_LATCH_U: begin
        u_neg <= (sqb < sqc);
        u_mag <= div_q;
      end
      OP_LATCH_A: begin
        a_neg <= !u_neg && (u_mag != '0);
        a_mag <= div_q;
      end
      OP_LATCH_MU: begin
        mu_neg <= (dgb < dgc);
        mu_mag <= div_q;
      end
      OP_NU: begin
        nu_neg <= nu_sum[33];
        nu_mag <= nu_cl;
      end
      OP_NU_RND: nu_mag <= prod[60:30];
      OP_CELL:   cell_prod <= prod[60:30];
      OP_ACC_CELL: begin
        sum <= sum + {5'd0, cell_prod};
        if (cmd.target) tcell <= cell_prod;
      end
      default: dbc <= dbc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= (cmd.op == OP_RES_OK) || (cmd.op == OP_RES_ERR);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RES_OK) begin
      res.weight <= div_q;
      res.error  <= 1'b0;
    end else if (cmd.op == OP_RES_ERR) begin
      res.weight <= '0;
      res.error  <= 1'b1;
    end
  end

  always_comb begin
    status.sqrt_done = sqrt_done;
    status.div_done  = div_done;
    status.dbc_zero  = (dbc == '0);
    status.sum_zero  = (sum == '0);
  end

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> !res_valid)
    else $error("result strobe held for two cycles");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.op == OP_RES_ERR) |-> (res.error && res.weight == '0))
    else $error("error result with nonzero weight");

endmodule

[src/bfcw_ctrl.sv]
module bfcw_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          action,
  input  logic [bfcw_pkg::IDX_W-1:0]    atom_index,
  input  logic                          cfg_wen,
  input  logic [5:0]                    cfg_wdata,
  input  bfcw_pkg::bfcw_status_t        status,
  output logic                          busy,
  output bfcw_pkg::bfcw_cmd_t           cmd
);
  import bfcw_pkg::*;

  ctrl_state_t      state, state_next;
  logic [5:0]       atom_count;
  logic [CNT_W-1:0] b, b_next, c, c_next, n;
  logic [1:0]       k, k_next;
  logic [IDX_W-1:0] tidx, tidx_next;
  logic             pair, pair_next;

  assign n    = (atom_count > 6'(MAX_ATOMS)) ? CNT_W'(MAX_ATOMS) : CNT_W'(atom_count);
  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      atom_count <= '0;
      b          <= '0;
      c          <= '0;
      k          <= '0;
      tidx       <= '0;
      pair       <= 1'b0;
    end else begin
      state <= state_next;
      b     <= b_next;
      c     <= c_next;
      k     <= k_next;
      tidx  <= tidx_next;
      pair  <= pair_next;
      if (cfg_wen) atom_count <= cfg_wdata;
    end
  end

  always_comb begin
    state_next = state;
    b_next     = b;
    c_next     = c;
    k_next     = k;
    tidx_next  = tidx;
    pair_next  = pair;
    cmd.op     = OP_NOP;
    cmd.addr   = b[IDX_W-1:0];
    cmd.take   = 1'b0;
    cmd.target = (b[IDX_W-1:0] == tidx);
    unique case (state)
      ST_IDLE: begin
        cmd.take = start;
        if (start && action == ACT_QUERY) begin
          tidx_next = atom_index;
          b_next    = '0;
          state_next = ({1'b0, atom_index} >= n) ? ST_ERR : ST_P_RD;
        end
      end
      // per atom: grid distance and size root
      ST_P_RD: begin
        cmd.op = OP_READ;
        state_next = ST_P_DIFF;
      end
      ST_P_DIFF: begin
        cmd.op = OP_DIFF_G;
        pair_next = 1'b0;
        state_next = ST_MX;
      end
      ST_MX: begin
        cmd.op = OP_MUL_X;
        state_next = ST_MY;
      end
      ST_MY: begin
        cmd.op = OP_MUL_Y;
        state_next = ST_MZ;
      end
      ST_MZ: begin
        cmd.op = OP_MUL_Z;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.op = OP_ACC;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.op = OP_SQRT_DIST;
        state_next = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (status.sqrt_done) state_next = pair ? ST_C_DBC : ST_P_SIZE;
      end
      ST_P_SIZE: begin
        cmd.op = OP_SQRT_SIZE;
        state_next = ST_P_WAIT;
      end
      ST_P_WAIT: begin
        if (status.sqrt_done) state_next = ST_P_WR;
      end
      ST_P_WR: begin
        cmd.op = OP_WR_PRE;
        if (b == n - CNT_W'(1)) begin
          b_next = '0;
          state_next = ST_B_RD;
        end else begin
          b_next = b + CNT_W'(1);
          state_next = ST_P_RD;
        end
      end
      // pair walk
      ST_B_RD: begin
        cmd.op = OP_READ;
        state_next = ST_B_LATCH;
      end
      ST_B_LATCH: begin
        cmd.op = OP_LATCH_B;
        c_next = '0;
        state_next = ST_C_CHK;
      end
      ST_C_CHK: begin
        if (c == n) begin
          state_next = ST_B_END;
        end else if (c == b) begin
          c_next = c + CNT_W'(1);
        end else begin
          state_next = ST_C_RD;
        end
      end
      ST_C_RD: begin
        cmd.op = OP_READ;
        cmd.addr = c[IDX_W-1:0];
        state_next = ST_C_DIFF;
      end
      ST_C_DIFF: begin
        cmd.op = OP_DIFF_B;
        pair_next = 1'b1;
        state_next = ST_MX;
      end
      ST_C_DBC: begin
        cmd.op = OP_LATCH_DBC;
        state_next = ST_C_CHKZ;
      end
      ST_C_CHKZ: begin
        state_next = status.dbc_zero ? ST_ERR : ST_U_DIV;
      end
      ST_U_DIV: begin
        cmd.op = OP_DIV_U;
        state_next = ST_U_WAIT;
      end
      ST_U_WAIT: begin
        if (status.div_done) state_next = ST_U_LATCH;
      end
      ST_U_LATCH: begin
        cmd.op = OP_LATCH_U;
        state_next = ST_U2;
      end
      ST_U2: begin
        cmd.op = OP_MUL_UU;
        state_next = ST_A_DIV;
      end
      ST_A_DIV: begin
        cmd.op = OP_DIV_A;
        state_next = ST_A_WAIT;
      end
      ST_A_WAIT: begin
        if (status.div_done) state_next = ST_A_LATCH;
      end
      ST_A_LATCH: begin
        cmd.op = OP_LATCH_A;
        state_next = ST_MU_DIV;
      end
      ST_MU_DIV: begin
        cmd.op = OP_DIV_MU;
        state_next = ST_MU_WAIT;
      end
      ST_MU_WAIT: begin
        if (status.div_done) state_next = ST_MU_LATCH;
      end
      ST_MU_LATCH: begin
        cmd.op = OP_LATCH_MU;
        state_next = ST_MM;
      end
      ST_MM: begin
        cmd.op = OP_MUL_MM;
        state_next = ST_NA;
      end
      ST_NA: begin
        cmd.op = OP_MUL_NA;
        state_next = ST_NU;
      end
      ST_NU: begin
        cmd.op = OP_NU;
        k_next = '0;
        state_next = ST_R1;
      end
      // three smoothing rounds
      ST_R1: begin
        cmd.op = OP_MUL_NN;
        state_next = ST_R2;
      end
      ST_R2: begin
        cmd.op = OP_MUL_NM;
        state_next = ST_R3;
      end
      ST_R3: begin
        cmd.op = OP_NU_RND;
        if (k == 2'd2) begin
          state_next = ST_S;
        end else begin
          k_next = k + 2'd1;
          state_next = ST_R1;
        end
      end
      ST_S: begin
        cmd.op = OP_MUL_CS;
        state_next = ST_CELL;
      end
      ST_CELL: begin
        cmd.op = OP_CELL;
        c_next = c + CNT_W'(1);
        state_next = ST_C_CHK;
      end
      ST_B_END: begin
        cmd.op = OP_ACC_CELL;
        if (b == n - CNT_W'(1)) begin
          state_next = ST_F_CHK;
        end else begin
          b_next = b + CNT_W'(1);
          state_next = ST_B_RD;
        end
      end
      ST_F_CHK: begin
        state_next = status.sum_zero ? ST_ERR : ST_F_DIV;
      end
      ST_F_DIV: begin
        cmd.op = OP_DIV_W;
        state_next = ST_F_WAIT;
      end
      ST_F_WAIT: begin
        if (status.div_done) state_next = ST_OK;
      end
      ST_OK: begin
        cmd.op = OP_RES_OK;
        state_next = ST_IDLE;
      end
      ST_ERR: begin
        cmd.op = OP_RES_ERR;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_LOAD) |=> !busy)
    else $error("load kept the block busy");
  a_bad_target: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action == ACT_QUERY && {1'b0, atom_index} >= n)
      |=> state == ST_ERR)
    else $error("out-of-range target not flagged");

endmodule

[src/becke_fuzzy_cell_weight_unit.sv]
// Becke fuzzy-cell weight unit. A load (action 0) writes one atom entry; busy stays
// low. A query (action 1) walks every ordered pair of the first atom_count atoms
// (capped at 32) through one shared multiplier, a bit-serial square-root unit and a
// radix-2 divider; the sequencer runs them one after another, with one square root
// and three divisions per pair. The result shows on result for exactly one cycle
// with done high, the same cycle busy drops; the receiver cannot stall it, so it
// must take every transfer. No table clearing is done after reset: query only atoms
// that were loaded. Write atom_count only while busy is low.
module becke_fuzzy_cell_weight_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  bfcw_pkg::bfcw_in_t  item,
  output logic                done,
  output bfcw_pkg::bfcw_out_t result,
  input  logic                cfg_wen,
  input  logic [5:0]          cfg_wdata
);
  import bfcw_pkg::*;

  bfcw_cmd_t    cmd;
  bfcw_status_t status;

  bfcw_ctrl u_ctrl (
    .clk, .rst, .start, .action(item.action), .atom_index(item.atom_index),
    .cfg_wen, .cfg_wdata, .status, .busy, .cmd
  );

  bfcw_datapath u_dp (
    .clk, .rst, .cmd, .item, .status, .res_valid(done), .res(result)
  );

endmodule
